// ----- hdl/owsed_pkg.sv -----
package owsed_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int ENTRY_W = 96;
    localparam logic [30:0] EPS_RESET = 31'd8;

    typedef struct packed {
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] stamp;
        logic        last;
        logic        first;
    } item_t;

    typedef struct packed {
        logic [31:0] idx;
        logic        forced;
        logic        eot;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_RD_E, ST_LD_E, ST_EPSD, ST_RSQ0, ST_RSQ1, ST_RSQ2,
        ST_RD_M, ST_LD_M, ST_XM0, ST_XM1, ST_YM0, ST_YM1, ST_ABS,
        ST_XSQ0, ST_XSQ1, ST_XSQ2, ST_YSQ0, ST_YSQ1, ST_YSQ2, ST_CMP,
        ST_FIN, ST_RD_K, ST_LD_K, ST_DONE
    } state_t;

    function automatic logic [32:0] mag33(input logic [32:0] v);
        return v[32] ? (~v + 33'd1) : v;
    endfunction

    function automatic logic [67:0] mag68(input logic [67:0] v);
        return v[67] ? (~v + 68'd1) : v;
    endfunction

endpackage

// ----- hdl/owsed_ram.sv -----
module owsed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/owsed_front.sv -----
module owsed_front
    import owsed_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] lat,
    input  logic signed [31:0] lon,
    input  logic        [31:0] stamp,
    input  logic               final_point,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    item_t      slot_reg [2];
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       first_reg;
    logic       accept;
    logic       pop;
    item_t      new_item;

    assign in_stall = (count_reg == 2'd2);
    assign accept   = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    // first point of a track: reset, or the item after a final point
    always_comb
    begin
        new_item.lat   = lat;
        new_item.lon   = lon;
        new_item.stamp = stamp;
        new_item.last  = final_point;
        new_item.first = first_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            first_reg  <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
                first_reg  <= final_point;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (accept && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !accept)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ----- hdl/owsed_back.sv -----
module owsed_back
    import owsed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] kept_index,
    output logic        forced,
    output logic        end_of_run,
    output logic        end_of_track
);

    state_t          state_reg, state_next;
    logic [30:0]     eps_reg;
    logic [CW-1:0]   fill_reg, scan_reg, i_reg, i_inc;
    logic [AW-1:0]   base_reg;
    logic [31:0]     anchor_reg, seen_reg;
    logic            last_reg;
    logic [31:0]     s_lat_reg, s_lon_reg, s_time_reg;
    logic [31:0]     e_lat_reg, e_lon_reg;
    logic [31:0]     m_lat_reg, m_lon_reg, m_time_reg;
    logic [32:0]     d_reg, dlat_reg, dlon_reg, n_reg, alat_reg, alon_reg;
    logic [67:0]     xacc_reg, yacc_reg, xmag_reg, ymag_reg;
    logic [135:0]    acc_reg, rhs_reg;
    logic            pend_valid_reg, out_valid_reg, out_eor_reg;
    result_t         pend_reg, out_reg, new_res;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [31:0]     rd_lat, rd_lon, rd_time;

    logic [33:0]     mul_a, mul_b;
    logic            mul_neg;
    logic [67:0]     prod;
    logic [67:0]     sq_src;
    logic            produce, flush, advance, can_push, violate, d_zero, push;
    logic [CW-1:0]   k_slot;
    logic [32:0]     ex_lat, ex_lon;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] j);
        logic [SW-1:0] s;
        s = SW'(b) + SW'(j);
        if (s >= SW'(WINDOW_DEPTH))
        begin
            s = s - SW'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    owsed_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_lat    = ram_rdata[95:64];
    assign rd_lon    = ram_rdata[63:32];
    assign rd_time   = ram_rdata[31:0];
    assign ram_waddr = phys(base_reg, fill_reg);
    assign ram_wdata = {q_item.lat, q_item.lon, q_item.stamp};

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign kept_index   = out_reg.idx;
    assign forced       = out_reg.forced;
    assign end_of_track = out_reg.eot;
    assign end_of_run   = out_eor_reg;

    assign can_push = !out_valid_reg || !out_stall;
    assign advance  = !pend_valid_reg || can_push;
    assign violate  = (acc_reg > rhs_reg);
    assign d_zero   = (d_reg == 33'd0);
    assign i_inc    = i_reg + CW'(1);
    assign k_slot   = fill_reg - CW'(2);
    assign push     = (produce || flush) && advance && pend_valid_reg;
    assign ex_lat   = {e_lat_reg[31], e_lat_reg} - {rd_lat[31], rd_lat};
    assign ex_lon   = {e_lon_reg[31], e_lon_reg} - {rd_lon[31], rd_lon};

    // shared multiplier: operand select per step
    always_comb
    begin
        sq_src  = ((state_reg == ST_YSQ0) || (state_reg == ST_YSQ1) || (state_reg == ST_YSQ2))
                  ? ymag_reg : xmag_reg;
        mul_a   = 34'd0;
        mul_b   = 34'd0;
        mul_neg = 1'b0;
        unique case (state_reg)
            ST_EPSD:
            begin
                mul_a = {3'd0, eps_reg};
                mul_b = d_zero ? 34'd1 : {1'b0, mag33(d_reg)};
            end
            ST_XM0:
            begin
                mul_a   = {1'b0, mag33(d_reg)};
                mul_b   = {1'b0, mag33(alat_reg)};
                mul_neg = d_reg[32] ^ alat_reg[32];
            end
            ST_XM1:
            begin
                mul_a   = {1'b0, mag33(dlat_reg)};
                mul_b   = {1'b0, mag33(n_reg)};
                mul_neg = dlat_reg[32] ^ n_reg[32];
            end
            ST_YM0:
            begin
                mul_a   = {1'b0, mag33(d_reg)};
                mul_b   = {1'b0, mag33(alon_reg)};
                mul_neg = d_reg[32] ^ alon_reg[32];
            end
            ST_YM1:
            begin
                mul_a   = {1'b0, mag33(dlon_reg)};
                mul_b   = {1'b0, mag33(n_reg)};
                mul_neg = dlon_reg[32] ^ n_reg[32];
            end
            ST_RSQ0, ST_XSQ0, ST_YSQ0:
            begin
                mul_a = sq_src[33:0];
                mul_b = sq_src[33:0];
            end
            ST_RSQ1, ST_XSQ1, ST_YSQ1:
            begin
                mul_a = sq_src[67:34];
                mul_b = sq_src[33:0];
            end
            ST_RSQ2, ST_XSQ2, ST_YSQ2:
            begin
                mul_a = sq_src[67:34];
                mul_b = sq_src[67:34];
            end
            default:
            begin
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_CHECK;
            ST_CHECK: state_next = (scan_reg < fill_reg) ? ST_RD_E : ST_FIN;
            ST_RD_E:  state_next = ST_LD_E;
            ST_LD_E:  state_next = ST_EPSD;
            ST_EPSD:  state_next = ST_RSQ0;
            ST_RSQ0:  state_next = ST_RSQ1;
            ST_RSQ1:  state_next = ST_RSQ2;
            ST_RSQ2:  state_next = ST_RD_M;
            ST_RD_M:  state_next = ST_LD_M;
            ST_LD_M:  state_next = d_zero ? ST_ABS : ST_XM0;
            ST_XM0:   state_next = ST_XM1;
            ST_XM1:   state_next = ST_YM0;
            ST_YM0:   state_next = ST_YM1;
            ST_YM1:   state_next = ST_ABS;
            ST_ABS:   state_next = ST_XSQ0;
            ST_XSQ0:  state_next = ST_XSQ1;
            ST_XSQ1:  state_next = ST_XSQ2;
            ST_XSQ2:  state_next = ST_YSQ0;
            ST_YSQ0:  state_next = ST_YSQ1;
            ST_YSQ1:  state_next = ST_YSQ2;
            ST_YSQ2:  state_next = ST_CMP;
            ST_CMP:
            begin
                if (violate)
                begin
                    if (advance) state_next = ST_CHECK;
                end
                else
                begin
                    state_next = (i_inc < scan_reg) ? ST_RD_M : ST_CHECK;
                end
            end
            ST_FIN:
            begin
                if (last_reg)
                begin
                    if (advance) state_next = ST_DONE;
                end
                else
                begin
                    state_next = (fill_reg >= CW'(WINDOW_DEPTH)) ? ST_RD_K : ST_DONE;
                end
            end
            ST_RD_K:  state_next = ST_LD_K;
            ST_LD_K:  if (advance) state_next = ST_DONE;
            ST_DONE:  if (advance) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ram_raddr = phys(base_reg, i_reg);
        ram_we    = 1'b0;
        q_pop     = 1'b0;
        produce   = 1'b0;
        flush     = 1'b0;
        new_res   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_we = q_valid;
                q_pop  = q_valid;
            end
            ST_RD_E:
            begin
                ram_raddr = phys(base_reg, scan_reg);
            end
            ST_CMP:
            begin
                produce     = violate;
                new_res.idx = anchor_reg + 32'(i_reg);
            end
            ST_FIN:
            begin
                produce     = last_reg;
                new_res.idx = seen_reg;
                new_res.eot = 1'b1;
            end
            ST_RD_K:
            begin
                ram_raddr = phys(base_reg, k_slot);
            end
            ST_LD_K:
            begin
                // hold the address so the read data stays while stalled
                ram_raddr      = phys(base_reg, k_slot);
                produce        = 1'b1;
                new_res.idx    = anchor_reg + 32'(k_slot);
                new_res.forced = 1'b1;
            end
            ST_DONE:
            begin
                flush = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            eps_reg        <= EPS_RESET;
            fill_reg       <= '0;
            scan_reg       <= CW'(2);
            i_reg          <= CW'(1);
            base_reg       <= '0;
            anchor_reg     <= 32'd0;
            seen_reg       <= 32'd0;
            last_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            out_eor_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                eps_reg <= cfg_data;
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= pend_reg;
                out_eor_reg   <= flush;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (produce && advance)
            begin
                pend_valid_reg <= 1'b1;
                pend_reg       <= new_res;
            end
            else if (flush && advance)
            begin
                pend_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        fill_reg <= fill_reg + CW'(1);
                        last_reg <= q_item.last;
                        if (q_item.first)
                        begin
                            pend_valid_reg <= 1'b1;
                            pend_reg       <= '0;
                        end
                    end
                end
                ST_RSQ2:
                begin
                    i_reg <= CW'(1);
                end
                ST_CMP:
                begin
                    if (violate)
                    begin
                        if (advance)
                        begin
                            fill_reg   <= fill_reg - i_reg;
                            base_reg   <= phys(base_reg, i_reg);
                            anchor_reg <= anchor_reg + 32'(i_reg);
                            scan_reg   <= CW'(2);
                        end
                    end
                    else if (i_inc < scan_reg)
                    begin
                        i_reg <= i_inc;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + CW'(1);
                    end
                end
                ST_FIN:
                begin
                    if (last_reg)
                    begin
                        if (advance)
                        begin
                            fill_reg   <= '0;
                            scan_reg   <= CW'(2);
                            base_reg   <= '0;
                            anchor_reg <= 32'd0;
                            seen_reg   <= 32'd0;
                        end
                    end
                    else
                    begin
                        seen_reg <= seen_reg + 32'd1;
                    end
                end
                ST_LD_K:
                begin
                    if (advance)
                    begin
                        base_reg   <= phys(base_reg, k_slot);
                        anchor_reg <= anchor_reg + 32'(k_slot);
                        fill_reg   <= CW'(2);
                        scan_reg   <= CW'(2);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && (fill_reg == '0))
                begin
                    s_lat_reg  <= q_item.lat;
                    s_lon_reg  <= q_item.lon;
                    s_time_reg <= q_item.stamp;
                end
            end
            ST_LD_E:
            begin
                e_lat_reg <= rd_lat;
                e_lon_reg <= rd_lon;
                d_reg     <= {1'b0, rd_time} - {1'b0, s_time_reg};
                dlat_reg  <= {rd_lat[31], rd_lat} - {s_lat_reg[31], s_lat_reg};
                dlon_reg  <= {rd_lon[31], rd_lon} - {s_lon_reg[31], s_lon_reg};
            end
            ST_EPSD:
            begin
                xmag_reg <= prod;
            end
            ST_RSQ0, ST_XSQ0:
            begin
                acc_reg <= {68'd0, prod};
            end
            ST_RSQ1, ST_XSQ1, ST_YSQ1:
            begin
                acc_reg <= acc_reg + ({68'd0, prod} << 35);
            end
            ST_RSQ2:
            begin
                rhs_reg <= acc_reg + ({68'd0, prod} << 68);
            end
            ST_XSQ2, ST_YSQ2:
            begin
                acc_reg <= acc_reg + ({68'd0, prod} << 68);
            end
            ST_YSQ0:
            begin
                acc_reg <= acc_reg + {68'd0, prod};
            end
            ST_LD_M:
            begin
                m_lat_reg  <= rd_lat;
                m_lon_reg  <= rd_lon;
                m_time_reg <= rd_time;
                n_reg      <= {1'b0, rd_time} - {1'b0, s_time_reg};
                alat_reg   <= {s_lat_reg[31], s_lat_reg} - {rd_lat[31], rd_lat};
                alon_reg   <= {s_lon_reg[31], s_lon_reg} - {rd_lon[31], rd_lon};
                // zero time span: distance to the window end itself
                xacc_reg   <= {{35{ex_lat[32]}}, ex_lat};
                yacc_reg   <= {{35{ex_lon[32]}}, ex_lon};
            end
            ST_XM0:
            begin
                xacc_reg <= mul_neg ? (68'd0 - prod) : prod;
            end
            ST_XM1:
            begin
                xacc_reg <= mul_neg ? (xacc_reg - prod) : (xacc_reg + prod);
            end
            ST_YM0:
            begin
                yacc_reg <= mul_neg ? (68'd0 - prod) : prod;
            end
            ST_YM1:
            begin
                yacc_reg <= mul_neg ? (yacc_reg - prod) : (yacc_reg + prod);
            end
            ST_ABS:
            begin
                xmag_reg <= mag68(xacc_reg);
                ymag_reg <= mag68(yacc_reg);
            end
            ST_CMP:
            begin
                if (violate && advance)
                begin
                    s_lat_reg  <= m_lat_reg;
                    s_lon_reg  <= m_lon_reg;
                    s_time_reg <= m_time_reg;
                end
            end
            ST_LD_K:
            begin
                if (advance)
                begin
                    s_lat_reg  <= rd_lat;
                    s_lon_reg  <= rd_lon;
                    s_time_reg <= rd_time;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_scan_min: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg >= CW'(2))
        else $error("scan end below two");

    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_M) |-> ((i_reg != '0) && (i_reg < scan_reg) && (scan_reg < fill_reg)))
        else $error("tested point not interior");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left over between points");
`endif

endmodule

// ----- hdl/opening_window_sed_simplifier_core.sv -----
// Opening-window trajectory simplifier with synchronized Euclidean distance.
// Input channel (in_valid/in_stall): one trajectory point per transaction,
// lat/lon signed, stamp unsigned, final_point on the last point of a track.
// Output channel (out_valid/out_stall): one kept point index per transaction;
// end_of_run marks the last result caused by one input point, end_of_track the
// final index, forced a point kept because the 32-entry window store filled.
// Configuration (cfg_valid/cfg_ready, epsilon): write only while idle.
// A two-entry queue decouples input acceptance from the scan engine.
// Scan: each interior point test runs on the shared 34x34 multiplier (SED
// cross terms, then two three-part squares and a compare); the cross terms
// are skipped when the time span is zero, and each window end first forms
// epsilon^2*span^2. A new anchor restarts the scan of the buffered points.
// A result waits in one pending slot until the next result is found or the
// scan of its point ends, then moves to the output register.
// Reset empties the queue and the output register and starts a new track at
// index 0 with epsilon = 8. When the receiver stalls, the output transaction
// holds and the engine waits once its one pending result slot is also full.
module opening_window_sed_simplifier_core
    import owsed_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [30:0] epsilon,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] lat,
    input  logic signed [31:0] lon,
    input  logic        [31:0] stamp,
    input  logic               final_point,
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [31:0] kept_index,
    output logic               forced,
    output logic               end_of_run,
    output logic               end_of_track
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    owsed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .lat        (lat),
        .lon        (lon),
        .stamp      (stamp),
        .final_point(final_point),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    owsed_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (epsilon),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kept_index  (kept_index),
        .forced      (forced),
        .end_of_run  (end_of_run),
        .end_of_track(end_of_track)
    );

endmodule

// ----- verif/opening_window_sed_simplifier_core_test.sv -----
`timescale 1ns / 1ps

module opening_window_sed_simplifier_core_test;
    import owsed_pkg::*;

    localparam int IDLE_LIMIT  = 200000;
    localparam int CFG_SETTLE  = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic [31:0] idx;
        logic        frc;
        logic        eor;
        logic        eot;
    } kept_t;

    typedef struct {
        logic [31:0] la;
        logic [31:0] lo;
        logic [31:0] st;
        logic        fin;
        bit          solo;   // lone-point track: result pair typed in below
    } point_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] epsilon;
    logic        in_valid;
    logic        in_stall;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic [31:0] stamp;
    logic        final_point;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] kept_index;
    logic        forced;
    logic        end_of_run;
    logic        end_of_track;

    // predictor state
    logic [30:0] eps_q;
    logic [31:0] win_lat [WINDOW_DEPTH];
    logic [31:0] win_lon [WINDOW_DEPTH];
    logic [31:0] win_time [WINDOW_DEPTH];
    int unsigned anchor_q;
    int unsigned seen_q;
    int          fill_q;
    int          scan_q;

    kept_t kept_queue[$];
    int    failures;
    int    results_seen;
    int    idle_cycles = 0;
    bit    calm;

    opening_window_sed_simplifier_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .epsilon      (epsilon),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .lat          (lat),
        .lon          (lon),
        .stamp        (stamp),
        .final_point  (final_point),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kept_index   (kept_index),
        .forced       (forced),
        .end_of_run   (end_of_run),
        .end_of_track (end_of_track)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic bit sed_exceeds(int m, int e);
        longint slat, slon, mlat, mlon, elat, elon, d, n;
        wide_t  x, y, lhs, rhs, eps;
        slat = longint'($signed(win_lat[0]));
        slon = longint'($signed(win_lon[0]));
        mlat = longint'($signed(win_lat[m]));
        mlon = longint'($signed(win_lon[m]));
        elat = longint'($signed(win_lat[e]));
        elon = longint'($signed(win_lon[e]));
        d = longint'(win_time[e]) - longint'(win_time[0]);
        n = longint'(win_time[m]) - longint'(win_time[0]);
        eps = wide_t'(longint'(eps_q));
        if (d == 0)
        begin
            x = wide_t'(elat - mlat);
            y = wide_t'(elon - mlon);
            rhs = eps * eps;
        end
        else
        begin
            x = wide_t'(d) * wide_t'(slat - mlat) + wide_t'(elat - slat) * wide_t'(n);
            y = wide_t'(d) * wide_t'(slon - mlon) + wide_t'(elon - slon) * wide_t'(n);
            rhs = eps * eps * wide_t'(d) * wide_t'(d);
        end
        lhs = x * x + y * y;
        return lhs > rhs;
    endfunction

    function automatic void move_anchor(int k);
        for (int j = 0; j < fill_q - k; j++)
        begin
            win_lat[j]  = win_lat[j + k];
            win_lon[j]  = win_lon[j + k];
            win_time[j] = win_time[j + k];
        end
        fill_q   = fill_q - k;
        anchor_q = anchor_q + k;
        scan_q   = 2;
    endfunction

    function automatic void clear_track();
        anchor_q = 0;
        seen_q   = 0;
        fill_q   = 0;
        scan_q   = 2;
    endfunction

    function automatic void append_kept(ref kept_t q[$], input kept_t r);
        q.insert(q.size(), r);
    endfunction

    function automatic void predict_kept(input logic [31:0] la, input logic [31:0] lo,
                                         input logic [31:0] st, input logic fin,
                                         ref kept_t found[$]);
        int i;
        found.delete();
        win_lat[fill_q]  = la;
        win_lon[fill_q]  = lo;
        win_time[fill_q] = st;
        fill_q++;
        if (seen_q == 0)
            append_kept(found, kept_t'{32'd0, 1'b0, 1'b0, 1'b0});
        while (scan_q < fill_q)
        begin
            i = 1;
            while (i < scan_q && !sed_exceeds(i, scan_q))
                i++;
            if (i < scan_q)
            begin
                append_kept(found, kept_t'{anchor_q + i, 1'b0, 1'b0, 1'b0});
                move_anchor(i);
            end
            else
                scan_q++;
        end
        if (fin)
        begin
            append_kept(found, kept_t'{seen_q, 1'b0, 1'b0, 1'b1});
            clear_track();
        end
        else
        begin
            seen_q++;
            if (fill_q >= WINDOW_DEPTH)
            begin
                append_kept(found, kept_t'{anchor_q + fill_q - 2, 1'b1, 1'b0, 1'b0});
                move_anchor(fill_q - 2);
            end
        end
        if (found.size() > 0)
            found[found.size() - 1].eor = 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_point(input logic [31:0] la, input logic [31:0] lo,
                              input logic [31:0] st, input logic fin, input bit solo);
        int    gap;
        kept_t found[$];
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        lat         <= la;
        lon         <= lo;
        stamp       <= st;
        final_point <= fin;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_kept(la, lo, st, fin, found);
        if (solo)
        begin
            append_kept(kept_queue, kept_t'{32'd0, 1'b0, 1'b0, 1'b0});
            append_kept(kept_queue, kept_t'{32'd0, 1'b0, 1'b1, 1'b1});
        end
        else
            foreach (found[j])
                append_kept(kept_queue, found[j]);
        @(negedge clk);
    endtask

    task automatic write_epsilon(input logic [30:0] value);
        in_valid <= 1'b0;
        while (kept_queue.size() != 0)
            @(negedge clk);
        repeat (CFG_SETTLE) @(negedge clk);
        epsilon   <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        eps_q = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_tracks(input int items, input bit with_long);
        int          sent, len, spread;
        int          cur_lat, cur_lon;
        logic [31:0] cur_t, pl, po;
        bit          long_done;
        sent = 0;
        long_done = !with_long;
        while (sent < items || !long_done)
        begin
            if (!long_done && $urandom_range(0, 3) == 0)
            begin
                len = $urandom_range(34, 40);
                long_done = 1;
            end
            else if ($urandom_range(0, 9) == 0)
                len = 1;
            else
                len = $urandom_range(2, 10);
            case ($urandom_range(0, 2))
                0: spread = 4;
                1: spread = 64;
                default: spread = 4096;
            endcase
            cur_lat = $urandom;
            cur_lon = $urandom;
            cur_t   = $urandom;
            for (int p = 0; p < len; p++)
            begin
                if ($urandom_range(0, 15) == 0)
                    calm = !calm;
                if ($urandom_range(0, 9) == 0)
                begin
                    pl = $urandom;
                    po = $urandom;
                    cur_t = $urandom;
                end
                else
                begin
                    cur_lat += $urandom_range(0, 2 * spread) - spread;
                    cur_lon += $urandom_range(0, 2 * spread) - spread;
                    if ($urandom_range(0, 19) == 0)
                        cur_t -= $urandom_range(0, 8);
                    else
                        cur_t += $urandom_range(0, 8);
                    pl = cur_lat;
                    po = cur_lon;
                end
                send_point(pl, po, cur_t, p == len - 1, 1'b0);
                sent++;
            end
        end
        in_valid <= 1'b0;
    endtask

    point_row_t directed_rows [] = '{
        '{32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1},
        '{32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b1},
        '{32'd0,         32'd0,         32'd0,         1'b0, 1'b0},
        '{32'd100,       32'd100,       32'd10,        1'b1, 1'b0},
        // interior point far off the segment
        '{32'd0,         32'd0,         32'd0,         1'b0, 1'b0},
        '{32'd1000,      32'd0,         32'd5,         1'b0, 1'b0},
        '{32'd0,         32'd0,         32'd10,        1'b1, 1'b0},
        // zero time span
        '{32'd0,         32'd0,         32'd7,         1'b0, 1'b0},
        '{32'd5,         32'd500,       32'd7,         1'b0, 1'b0},
        '{32'd10,        32'd0,         32'd7,         1'b1, 1'b0},
        // stamps going backwards
        '{32'd0,         32'd0,         32'd100,       1'b0, 1'b0},
        '{32'd50,        -32'sd50,      32'd90,        1'b0, 1'b0},
        '{32'd100,       32'd0,         32'd80,        1'b0, 1'b0},
        '{32'd0,         32'd0,         32'd0,         1'b1, 1'b0},
        '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 1'b0, 1'b0},
        '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b0, 1'b0},
        '{32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0},
        '{32'd0,         32'd0,         32'hffff_ffff, 1'b0, 1'b0},
        '{32'd3,         32'd3,         32'h0000_0000, 1'b0, 1'b0},
        '{-32'sd9,       32'd9,         32'h8000_0000, 1'b1, 1'b0}
    };

    initial
    begin
        failures    = 0;
        calm        = 0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        epsilon     = '0;
        in_valid    = 1'b0;
        lat         = '0;
        lon         = '0;
        stamp       = '0;
        final_point = 1'b0;
        eps_q       = EPS_RESET;
        clear_track();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
            send_point(directed_rows[r].la, directed_rows[r].lo, directed_rows[r].st,
                       directed_rows[r].fin, directed_rows[r].solo);
        in_valid <= 1'b0;

        write_epsilon(31'd0);
        run_tracks(15, 1'b0);
        write_epsilon(31'h7fff_ffff);
        run_tracks(5, 1'b1);
        write_epsilon(31'd50);
        run_tracks(15, 1'b0);
        write_epsilon(31'($urandom_range(1, 5000)));
        run_tracks(15, 1'b0);

        while (kept_queue.size() != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
        if (failures == 0)
            $display("opening_window_sed_simplifier_core regression: pass");
        else
            $display("opening_window_sed_simplifier_core regression: fail");
        $finish;
    end

    // result side
    initial
    begin
        int    n;
        bit    held;
        kept_t exp_r;
        held = 0;
        results_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            n = calm ? 0 : $urandom_range(0, 16);
            if (!held && results_seen >= 30)
            begin
                // long hold so the core backs up into its input
                held = 1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            results_seen++;
            if (kept_queue.size() == 0)
            begin
                $error("unexpected transaction: kept_index %0d", kept_index);
                failures++;
            end
            else
            begin
                exp_r = kept_queue.pop_front();
                if (kept_index !== exp_r.idx)
                begin
                    $error("kept_index expected %0d actual %0d", exp_r.idx, kept_index);
                    failures++;
                end
                if (forced !== exp_r.frc)
                begin
                    $error("forced expected %0b actual %0b", exp_r.frc, forced);
                    failures++;
                end
                if (end_of_run !== exp_r.eor)
                begin
                    $error("end_of_run expected %0b actual %0b", exp_r.eor, end_of_run);
                    failures++;
                end
                if (end_of_track !== exp_r.eot)
                begin
                    $error("end_of_track expected %0b actual %0b", exp_r.eot, end_of_track);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("opening_window_sed_simplifier_core regression: fail");
            $finish;
        end
    end

endmodule
